// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared request and status codes plus the command and status bundles that
// pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    // width of the tag fields on the ports
    localparam int TAG_PORT_W = 32;

    // request codes
    typedef enum logic [2:0] {
        REQ_PUSH_REAR  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_DUMP       = 3'd4
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic    push;        // store tag_in at one end
        logic    pop;         // read and remove the tag at one end
        logic    front;       // end selector for push and pop
        logic    dump_start;  // read the front tag, scan pointer to head
        logic    scan_step;   // advance scan pointer and read that slot
        logic    ld_code;     // load a result word with no tag
        status_t code;        // status for ld_code
        logic    ld_tag;      // load a result word from the ram read data
        logic    tag_last;    // last flag for ld_tag
    } cdq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_end;       // scan pointer sits on the rear tag
    } cdq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cdq_dp.sv -----
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: head, tail and empty registers, the scan pointer for dumps,
// the tag store and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH     = 8,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cdq_cmd_t              cmd,
    output cdq_stat_t                  stat,
    input  wire logic [TAG_PORT_W-1:0] tag_in,
    output status_t                    status,
    output logic      [TAG_PORT_W-1:0] tag_out,
    output logic                       last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             empty_reg, empty_next;

    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec, scan_inc;

    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [TAG_WIDTH-1:0]  wr_tag, rd_data;

    status_t               status_reg;
    logic [TAG_PORT_W-1:0] tag_out_reg;
    logic                  last_reg;

    // wrapping neighbors of the pointers
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign scan_inc = (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;

    // status toward the controller
    assign stat.empty    = empty_reg;
    assign stat.full     = !empty_reg && (tail_inc == head_reg);
    assign stat.scan_end = (scan_reg == tail_reg);

    // tag width adaption between ports and store
    assign wr_tag = TAG_WIDTH'(tag_in);

    // pointer updates and store access
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        scan_next  = scan_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_inc;
        rd_en      = 1'b0;
        rd_addr    = head_reg;

        if (cmd.push)
        begin
            wr_en      = 1'b1;
            empty_next = 1'b0;
            priority if (empty_reg)
            begin
                head_next = '0;
                tail_next = '0;
                wr_addr   = '0;
            end
            else if (cmd.front)
            begin
                head_next = head_dec;
                wr_addr   = head_dec;
            end
            else
            begin
                tail_next = tail_inc;
                wr_addr   = tail_inc;
            end
        end

        if (cmd.pop)
        begin
            rd_en   = 1'b1;
            rd_addr = cmd.front ? head_reg : tail_reg;
            priority if (head_reg == tail_reg)
            begin
                empty_next = 1'b1;
                head_next  = '0;
                tail_next  = '0;
            end
            else if (cmd.front)
            begin
                head_next = head_inc;
            end
            else
            begin
                tail_next = tail_dec;
            end
        end

        if (cmd.dump_start)
        begin
            rd_en     = 1'b1;
            rd_addr   = head_reg;
            scan_next = head_reg;
        end

        if (cmd.scan_step)
        begin
            rd_en     = 1'b1;
            rd_addr   = scan_inc;
            scan_next = scan_inc;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            scan_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            scan_reg  <= scan_next;
            empty_reg <= empty_next;
        end
    end

    // tag store
    cdq_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_tag),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_code)
        begin
            status_reg  <= cmd.code;
            tag_out_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.ld_tag)
        begin
            status_reg  <= ST_OK;
            tag_out_reg <= TAG_PORT_W'(rd_data);
            last_reg    <= cmd.tag_last;
        end
    end

    assign status  = status_reg;
    assign tag_out = tag_out_reg;
    assign last    = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque controller: decodes requests, sequences store reads for pops and
// dumps, and runs the handshake on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_t      req_type,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    input  wire cdq_stat_t stat,
    output cdq_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   dump_reg, dump_next;
    logic   req_acc;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign req_acc   = req_valid && (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        dump_next  = dump_reg;
        cmd        = '0;
        cmd.code   = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (req_type)
                        REQ_PUSH_REAR, REQ_PUSH_FRONT:
                        begin
                            cmd.ld_code = 1'b1;
                            if (stat.full)
                            begin
                                cmd.code = ST_FULL;
                            end
                            else
                            begin
                                cmd.push  = 1'b1;
                                cmd.front = (req_type == REQ_PUSH_FRONT);
                            end
                            state_next = S_OUT;
                        end
                        REQ_POP_FRONT, REQ_POP_REAR:
                        begin
                            dump_next = 1'b0;
                            if (stat.empty)
                            begin
                                cmd.ld_code = 1'b1;
                                cmd.code    = ST_EMPTY;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                cmd.front  = (req_type == REQ_POP_FRONT);
                                state_next = S_RD;
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                dump_next   = 1'b0;
                                cmd.ld_code = 1'b1;
                                cmd.code    = ST_EMPTY;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                dump_next      = 1'b1;
                                cmd.dump_start = 1'b1;
                                state_next     = S_RD;
                            end
                        end
                        default:
                        begin
                            // unknown request: dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // read data is valid now
                cmd.ld_tag   = 1'b1;
                cmd.tag_last = dump_reg ? stat.scan_end : 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    if (dump_reg && !stat.scan_end)
                    begin
                        cmd.scan_step = 1'b1;
                        state_next    = S_RD;
                    end
                    else
                    begin
                        dump_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dump_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/circular_deque_controller.sv -----
// ----------------------------------------------------------------------------
// circular_deque_controller
// Double-ended queue of tags kept in a circular store of DEPTH slots.
// ----------------------------------------------------------------------------
// Requests push a tag at the rear or front, pop one from the front or rear,
// or dump all queued tags front to rear without changing the queue. Each
// request gives one result word (status, tag_out, last), except a dump of a
// non-empty queue, which gives one word per queued tag with last set on the
// rear tag, and an unknown request code, which gives none. One request is in
// work at a time: req_stall is low only when the block is idle. A push, or
// any request that ends in a full or empty status, shows its word in the
// next cycle; a pop and every dumped tag first pass through a read state for
// the registered read of the tag store, then show their word. The store has
// no reset; only slots that hold queued tags are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_controller
    import cdq_pkg::*;
#(
    parameter int DEPTH     = 8,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic [2:0]            req_type,
    input  wire logic [TAG_PORT_W-1:0] tag_in,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic      [1:0]            status,
    output logic      [TAG_PORT_W-1:0] tag_out,
    output logic                       last
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;
    status_t   status_code;

    // sequencer
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_t'(req_type)),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // pointers, store and result word
    cdq_dp #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .tag_in  (tag_in),
        .status  (status_code),
        .tag_out (tag_out),
        .last    (last)
    );

    assign status = status_code;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular deque controller. A shadow deque
// predicts the words that each accepted request gives; a monitor compares
// every accepted word, field by field, with the oldest outstanding one.
// Directed requests cover the empty, single-tag, full and wrap cases. Random
// bursts then swing the deque between empty and full under mixed backpressure.
// ----------------------------------------------------------------------------
module testbench;
    import cdq_pkg::*;

    localparam int DEPTH      = 8;
    localparam int RAND_ITEMS = 432;

    // request codes the block ignores
    localparam logic [2:0] REQ_RSVD_A = 3'd5;
    localparam logic [2:0] REQ_RSVD_B = 3'd6;
    localparam logic [2:0] REQ_RSVD_C = 3'd7;

    typedef struct {
        logic [2:0]            op;
        logic [TAG_PORT_W-1:0] tag;
    } req_item_t;

    typedef struct {
        status_t               status;
        logic [TAG_PORT_W-1:0] tag;
        logic                  last;
    } rsp_word_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [2:0]            req_type  = 3'd0;
    logic [TAG_PORT_W-1:0] tag_in    = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [1:0]            status;
    logic [TAG_PORT_W-1:0] tag_out;
    logic                  last;

    req_item_t send_q[$];
    rsp_word_t owed_words[$];
    int        total_items = 0;
    int        dispatched  = 0;
    int        mismatches  = 0;

    // shadow copy of the deque
    logic [TAG_PORT_W-1:0] dq_slot [DEPTH];
    int unsigned           dq_head  = 0;
    int unsigned           dq_tail  = 0;
    bit                    dq_empty = 1'b1;

    circular_deque_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .tag_in    (tag_in),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .tag_out   (tag_out),
        .last      (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned step_up(int unsigned i);
        return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function automatic int unsigned step_down(int unsigned i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic void owe(status_t st, logic [TAG_PORT_W-1:0] tag, logic lst);
        rsp_word_t w;
        w.status = st;
        w.tag    = tag;
        w.last   = lst;
        owed_words.push_back(w);
    endfunction

    // apply one accepted request to the shadow deque and queue its words
    function automatic void track_request(logic [2:0] op, logic [TAG_PORT_W-1:0] tag);
        int unsigned idx;
        bit          at_rear;
        case (op)
            REQ_PUSH_REAR, REQ_PUSH_FRONT:
            begin
                if (!dq_empty && step_up(dq_tail) == dq_head)
                begin
                    owe(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    // the first tag always lands in slot zero
                    if (dq_empty)
                    begin
                        dq_head    = 0;
                        dq_tail    = 0;
                        dq_empty   = 1'b0;
                        dq_slot[0] = tag;
                    end
                    else if (op == REQ_PUSH_REAR)
                    begin
                        dq_tail          = step_up(dq_tail);
                        dq_slot[dq_tail] = tag;
                    end
                    else
                    begin
                        dq_head          = step_down(dq_head);
                        dq_slot[dq_head] = tag;
                    end
                    owe(ST_OK, '0, 1'b1);
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (dq_empty)
                begin
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    idx = (op == REQ_POP_FRONT) ? dq_head : dq_tail;
                    owe(ST_OK, dq_slot[idx], 1'b1);
                    // removing the only tag rewinds both pointers
                    if (dq_head == dq_tail)
                    begin
                        dq_empty = 1'b1;
                        dq_head  = 0;
                        dq_tail  = 0;
                    end
                    else if (op == REQ_POP_FRONT)
                    begin
                        dq_head = step_up(dq_head);
                    end
                    else
                    begin
                        dq_tail = step_down(dq_tail);
                    end
                end
            end
            REQ_DUMP:
            begin
                if (dq_empty)
                begin
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    idx     = dq_head;
                    at_rear = 1'b0;
                    while (!at_rear)
                    begin
                        at_rear = (idx == dq_tail);
                        owe(ST_OK, dq_slot[idx], at_rear);
                        idx = step_up(idx);
                    end
                end
            end
            default:
            begin
                // unknown codes give no word
            end
        endcase
    endfunction

    // idle percentages per phase of the run
    function automatic int sender_idle_pct();
        int phase;
        phase = (total_items == 0) ? 2 : (dispatched * 3) / total_items;
        return (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        int phase;
        phase = (total_items == 0) ? 2 : (dispatched * 3) / total_items;
        return (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
    endfunction

    function automatic void add_req(logic [2:0] op, logic [TAG_PORT_W-1:0] tag);
        req_item_t it;
        it.op  = op;
        it.tag = tag;
        send_q.push_back(it);
    endfunction

    function automatic logic [TAG_PORT_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        return $urandom;
    endfunction

    // request driver
    always @(posedge clk)
    begin : driver
        req_item_t nxt;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                track_request(req_type, tag_in);
            if (!req_valid || !req_stall)
            begin
                if (send_q.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    nxt        = send_q.pop_front();
                    req_valid <= 1'b1;
                    req_type  <= nxt.op;
                    tag_in    <= nxt.tag;
                    dispatched++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and backpressure
    always @(posedge clk)
    begin : monitor
        rsp_word_t w;
        if (rst_n)
        begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("word with none outstanding: status %0d tag_out %h last %0d",
                           status, tag_out, last);
                    mismatches++;
                end
                else
                begin
                    w = owed_words.pop_front();
                    if (status !== w.status)
                    begin
                        $error("status: expected %0d, got %0d", w.status, status);
                        mismatches++;
                    end
                    if (tag_out !== w.tag)
                    begin
                        $error("tag_out: expected %h, got %h", w.tag, tag_out);
                        mismatches++;
                    end
                    if (last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int         n_rand;
        int         mode;
        int         burst;
        int         roll;
        int         push_pct;
        logic [2:0] op;

        // empty deque: pops and dump report empty
        add_req(REQ_POP_FRONT, $urandom);
        add_req(REQ_POP_REAR, $urandom);
        add_req(REQ_DUMP, $urandom);
        // single tag pushed at either end, then popped from the other
        add_req(REQ_PUSH_FRONT, '1);
        add_req(REQ_DUMP, '0);
        add_req(REQ_POP_REAR, '0);
        add_req(REQ_PUSH_REAR, '0);
        add_req(REQ_POP_FRONT, '1);
        // ignored codes
        add_req(REQ_RSVD_A, $urandom);
        add_req(REQ_RSVD_B, $urandom);
        add_req(REQ_RSVD_C, $urandom);
        // fill to full with front pushes wrapping below slot zero
        for (int i = 0; i < DEPTH / 2; i++)
            add_req(REQ_PUSH_FRONT, $urandom);
        for (int i = 0; i < DEPTH / 2; i++)
            add_req(REQ_PUSH_REAR, $urandom);
        // pushes refused when full, then a full dump
        add_req(REQ_PUSH_REAR, '1);
        add_req(REQ_PUSH_FRONT, '1);
        add_req(REQ_DUMP, $urandom);
        add_req(REQ_POP_FRONT, $urandom);
        add_req(REQ_POP_REAR, $urandom);
        add_req(REQ_POP_FRONT, $urandom);

        // random bursts biased toward filling, draining or balanced
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            mode     = $urandom_range(2);
            burst    = $urandom_range(20, 5);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            repeat (burst)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    op = 3'(REQ_RSVD_A + $urandom_range(2));
                else if (roll < 11)
                    op = REQ_DUMP;
                else if ($urandom_range(99) < push_pct)
                    op = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
                else
                    op = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_REAR;
                add_req(op, pick_tag());
                if (op <= REQ_DUMP)
                    n_rand++;
            end
        end
        total_items = send_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (send_q.size() != 0 || req_valid)
            @(posedge clk);
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && owed_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_dp.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque_controller.sv
tb/testbench.sv
